FILE: hw/rtl/bcdd_pkg.sv
// ----------------------------------------------------------------------------
// bcdd_pkg
// Shared types and constants for the BCD digit display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdd_pkg;

   // Digit positions on the display.
   localparam int DISPLAY_DIGITS = 3;
   // Most results that one request may cause.
   localparam int MAX_RESULTS    = 3;
   // Digits that can be converted and shown.
   localparam int USABLE_DIGITS  = (DISPLAY_DIGITS > MAX_RESULTS) ? MAX_RESULTS
                                                                  : DISPLAY_DIGITS;
   localparam int IDX_W          = (USABLE_DIGITS > 1) ? $clog2(USABLE_DIGITS) : 1;

   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 4;
   localparam int INDEX_W        = 2;
   localparam int BCD_W          = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

   // Register map.
   localparam logic [2:0] ADDR_DIGIT_COUNT = 3'd0;

   // Reciprocal of ten: floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for any 32-bit v.
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   typedef logic [BCD_W-1:0] bcd_type;
   typedef bcd_type [USABLE_DIGITS-1:0] digits_type;

   // Data handed from one conversion cell to the next.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      digits_type         digits;
   } stage_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bcdd_cell.sv
// ----------------------------------------------------------------------------
// bcdd_cell
// One conversion cell: splits off the lowest decimal digit of the value and
// passes the quotient and the digits found so far to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdd_cell import bcdd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output logic           up_ready,
   input  wire stage_type up_data,
   output logic           dn_valid,
   input  wire logic      dn_ready,
   output stage_type      dn_data
);

   logic                     valid_ff;
   logic                     valid_in;
   stage_type                data_ff;
   stage_type                data_in;
   logic [2*VALUE_W-1:0]     product;
   logic [VALUE_W-1:0]       quotient;
   logic [VALUE_W-1:0]       times_ten;
   bcd_type                  digit;

   always_comb begin
      product   = {{VALUE_W{1'b0}}, up_data.value} * {{VALUE_W{1'b0}}, RECIP_TEN};
      quotient  = VALUE_W'(product >> RECIP_SHIFT);
      times_ten = (quotient << 3) + (quotient << 1);
      digit     = BCD_W'(up_data.value - times_ten);

      // The new digit enters at the top; after the last cell the units digit
      // sits at position zero.
      data_in.value = quotient;
      data_in.digits[USABLE_DIGITS-1] = digit;
      for (int j = 0; j < USABLE_DIGITS - 1; j++) begin
         data_in.digits[j] = up_data.digits[j+1];
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bcdd_emit.sv
// ----------------------------------------------------------------------------
// bcdd_emit
// Result stage: holds the converted digits of one request and sends one
// result per digit, units first, or a single error result.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdd_emit import bcdd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] digit_count,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire stage_type          up_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [INDEX_W-1:0]      rsp_digit_index,
   output logic [BCD_W-1:0]        rsp_digit_code,
   output logic                    rsp_count_error,
   output logic                    rsp_last_digit
);

   logic             valid_ff;
   logic             valid_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   digits_type       digits_ff;
   logic             count_error;
   logic             is_last;
   logic             load;

   assign count_error = digit_count > COUNT_W'(USABLE_DIGITS);
   assign is_last     = count_error ||
                        ((COUNT_W'(idx_ff) + COUNT_W'(1)) == digit_count);
   assign up_ready    = !valid_ff || (rsp_ready && is_last);
   assign load        = up_valid && up_ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         // A count of zero produces no result, so the request is dropped here.
         valid_in = digit_count != '0;
         idx_in   = '0;
      end else if (valid_ff && rsp_ready) begin
         valid_in = !is_last;
         idx_in   = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= up_data.digits;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_digit_index = count_error ? '0 : INDEX_W'(idx_ff);
   assign rsp_digit_code  = count_error ? '0 : digits_ff[idx_ff];
   assign rsp_count_error = count_error;
   assign rsp_last_digit  = is_last;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (COUNT_W'(idx_ff) < COUNT_W'(USABLE_DIGITS)))
      else $error("digit pointer beyond converted digits");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_error) |-> (rsp_last_digit && (idx_ff == '0)))
      else $error("error result is not a single final result");

   a_code_bcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_count_error) |-> (rsp_digit_code <= BCD_W'(9)))
      else $error("digit code is not a decimal digit");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_digit) |=> (rsp_valid &&
         (idx_ff == $past(idx_ff) + IDX_W'(1))))
      else $error("digit sequence did not advance");

endmodule

`default_nettype wire

FILE: hw/rtl/bcd_digit_display_driver.sv
// ----------------------------------------------------------------------------
// bcd_digit_display_driver
// Converts a 32-bit binary value into decimal digits for a multiplexed
// display and sends one strobe result per configured digit.
// ----------------------------------------------------------------------------
// Each request passes through a row of three registered conversion cells, each
// splitting off one decimal digit with a reciprocal multiply, before it
// reaches the result stage. The result stage then sends one result per cycle
// while rsp_ready is high: one result per configured digit, a single error
// result when digit_count exceeds the converted digits, and none for a count
// of zero. New requests keep entering the cells while earlier results wait,
// until the cells are full. digit_count lies at byte address 0; the user must
// write it only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_digit_display_driver import bcdd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [INDEX_W-1:0]      rsp_digit_index,
   output logic [BCD_W-1:0]        rsp_digit_code,
   output logic                    rsp_count_error,
   output logic                    rsp_last_digit,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [COUNT_W-1:0] digit_count_ff;
   logic [COUNT_W-1:0] digit_count_in;
   logic               csr_write;

   stage_type chain_data  [USABLE_DIGITS+1];
   logic      chain_valid [USABLE_DIGITS+1];
   logic      chain_ready [USABLE_DIGITS+1];

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      digit_count_in = digit_count_ff;
      if (csr_write && (csr_paddr == ADDR_DIGIT_COUNT)) begin
         digit_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= COUNT_RESET;
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_DIGIT_COUNT) ? 32'(digit_count_ff) : '0;

   // Row of conversion cells.
   assign chain_valid[0]       = req_valid;
   assign req_ready            = chain_ready[0];
   assign chain_data[0].value  = req_value;
   assign chain_data[0].digits = '0;

   for (genvar i = 0; i < USABLE_DIGITS; i++) begin : g_cell
      bcdd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   bcdd_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .digit_count     (digit_count_ff),
      .up_valid        (chain_valid[USABLE_DIGITS]),
      .up_ready        (chain_ready[USABLE_DIGITS]),
      .up_data         (chain_data[USABLE_DIGITS]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_index (rsp_digit_index),
      .rsp_digit_code  (rsp_digit_code),
      .rsp_count_error (rsp_count_error),
      .rsp_last_digit  (rsp_last_digit)
   );

endmodule

`default_nettype wire
